@@ rtl/core/crng_pkg.sv @@
// Shared constants, types and the modular fold for the combined LCG shuffle generator.
// No dependencies; imported by the top level and the checker.
package crng_pkg;

  localparam int unsigned WORD_W = 31;
  localparam int unsigned MUL_W  = 16;
  localparam int unsigned PROD_W = WORD_W + MUL_W;
  localparam int unsigned FOLD_W = 8;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [FOLD_W-1:0] fold_t;

  localparam word_t             MOD1  = 31'd2147483563;
  localparam word_t             MOD2  = 31'd2147483399;
  localparam logic [MUL_W-1:0]  MUL1  = 16'd40014;
  localparam logic [MUL_W-1:0]  MUL2  = 16'd40692;
  localparam word_t             SPAN  = MOD1 - 31'd1;
  localparam word_t             INIT2 = 31'd123456789;

  // 2^31 - modulus: weight of the bits above bit 30 after reduction
  localparam fold_t FOLD1 = FOLD_W'(32'h8000_0000 - {1'b0, MOD1});
  localparam fold_t FOLD2 = FOLD_W'(32'h8000_0000 - {1'b0, MOD2});

  localparam int TABLE_DEPTH_DEF = 32;

  // Reduce a word times a 16-bit multiplier modulo 2^31 - fold.
  // Folding the upper bits leaves a sum below twice the modulus,
  // so one conditional subtract finishes the job.
  function automatic word_t mod_fold(prod_t p, word_t m, fold_t f);
    logic [WORD_W:0] s;
    s = {1'b0, p[WORD_W-1:0]}
        + (WORD_W+1)'(32'(p[PROD_W-1:WORD_W]) * 32'(f));
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[WORD_W-1:0];
  endfunction

endpackage

@@ rtl/core/crng_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the shuffle table.
module crng_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/combined_lcg_shuffle_rng_top.sv @@
// Combined LCG random number generator with shuffle table: control, generators, output register.
// Depends on crng_pkg and crng_ram.
//
// Usage:
//   Input words carry in_cmd (0 = draw, 1 = reseed then draw) and in_seed.
//   Each accepted word yields exactly one out_value in 1..2147483562.
//   A draw before any seed behaves as a reseed with seed 0 (used as 1).
// Timing:
//   A plain draw runs in steps: the generator multiplies, the modular
//   fold plus the table read, then the subtract and table write-back.
//   A new word is taken only once the block is back in idle. The result
//   word is registered after the write-back and shows on out_valid.
//   A reseed runs TABLE_DEPTH+8 warm-up steps of the first generator, each
//   a multiply, then a fold and, in the last TABLE_DEPTH steps, a table
//   write; then the draw.
// Reset: control state and the first generator clear, the second loads INIT2;
//   the table is not cleared, every seed refills it before any read.
// Stall: a stalled result word holds in the output register; the block
//   finishes the next item up to its write-back and waits until it frees.
module combined_lcg_shuffle_rng_top
  import crng_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [30:0] in_seed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [30:0] out_value
);

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 8);
  localparam int QW     = 8;
  // Table index = last output / bucket, done as an exact reciprocal multiply
  localparam longint unsigned BUCKET = 64'd1 + 64'(SPAN) / 64'(TABLE_DEPTH);
  localparam int              DIV_SH = 31 + $clog2(BUCKET);
  localparam longint unsigned RECIP  = ((64'd1 << DIV_SH) + BUCKET - 64'd1) / BUCKET;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SMUL   = 3'd1;
  localparam logic [2:0] ST_SRED   = 3'd2;
  localparam logic [2:0] ST_DSTART = 3'd3;
  localparam logic [2:0] ST_DRED   = 3'd4;
  localparam logic [2:0] ST_DOUT   = 3'd5;

  logic [2:0]       state_r, state_nxt;
  word_t            x1_r, x1_nxt;
  word_t            x2_r, x2_nxt;
  word_t            lo_r, lo_nxt;
  logic             seeded_r, seeded_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  prod_t            mul1_r, mul2_r;
  logic [63:0]      qprod_r;
  logic             out_valid_r, out_valid_nxt;
  word_t            out_value_r, out_value_nxt;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  word_t            wr_data;
  logic             rd_en;
  word_t            rd_data;

  word_t            red1, red2;
  logic [63:0]      q_wide;
  logic [QW-1:0]    q;
  logic [IDX_W-1:0] idx_c;
  logic [31:0]      diff, wrapped;
  word_t            draw_val;
  word_t            seed_val;
  logic             accept, out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  assign red1 = mod_fold(mul1_r, MOD1, FOLD1);
  assign red2 = mod_fold(mul2_r, MOD2, FOLD2);

  assign q_wide = qprod_r >> DIV_SH;
  assign q      = q_wide[QW-1:0];
  assign idx_c  = (q >= QW'(TABLE_DEPTH)) ? IDX_W'(TABLE_DEPTH - 1) : q[IDX_W-1:0];

  // Difference wrapped into 1..SPAN
  assign diff     = {1'b0, rd_data} - {1'b0, x2_r};
  assign wrapped  = (diff[31] || (diff == 32'd0)) ? (diff + {1'b0, SPAN}) : diff;
  assign draw_val = wrapped[WORD_W-1:0];

  // A draw before any seed uses seed 0, which maps to 1
  assign seed_val = (in_cmd && (in_seed != 31'd0)) ? in_seed : 31'd1;

  always_comb begin
    state_nxt     = state_r;
    x1_nxt        = x1_r;
    x2_nxt        = x2_r;
    lo_nxt        = lo_r;
    seeded_nxt    = seeded_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = x1_r;
    rd_en         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd || !seeded_r) begin
            x1_nxt    = seed_val;
            x2_nxt    = seed_val;
            cnt_nxt   = CNT_W'(TABLE_DEPTH + 7);
            state_nxt = ST_SMUL;
          end else begin
            state_nxt = ST_DRED;
          end
        end
      end
      ST_SMUL: begin
        state_nxt = ST_SRED;
      end
      ST_SRED: begin
        x1_nxt  = red1;
        wr_en   = (cnt_r < CNT_W'(TABLE_DEPTH));
        wr_addr = cnt_r[IDX_W-1:0];
        wr_data = red1;
        if (cnt_r == '0) begin
          lo_nxt     = red1;
          seeded_nxt = 1'b1;
          state_nxt  = ST_DSTART;
        end else begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = ST_SMUL;
        end
      end
      ST_DSTART: begin
        // let the multiply registers pick up the warmed-up state
        state_nxt = ST_DRED;
      end
      ST_DRED: begin
        x1_nxt    = red1;
        x2_nxt    = red2;
        rd_en     = 1'b1;
        idx_nxt   = idx_c;
        state_nxt = ST_DOUT;
      end
      ST_DOUT: begin
        // write back the new first-generator value over the picked entry
        wr_en = 1'b1;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = draw_val;
          lo_nxt        = draw_val;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      x1_r        <= '0;
      x2_r        <= INIT2;
      lo_r        <= '0;
      seeded_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      x1_r        <= x1_nxt;
      x2_r        <= x2_nxt;
      lo_r        <= lo_nxt;
      seeded_r    <= seeded_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Free-running multiply registers; control consumes them in the next cycle
  always_ff @(posedge clk) begin
    mul1_r      <= prod_t'(x1_r) * prod_t'(MUL1);
    mul2_r      <= prod_t'(x2_r) * prod_t'(MUL2);
    qprod_r     <= 64'(lo_r) * RECIP;
    idx_r       <= idx_nxt;
    out_value_r <= out_value_nxt;
  end

  crng_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH),
    .ADDR_W(IDX_W)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(idx_c),
    .rd_data(rd_data)
  );

endmodule

@@ rtl/core/crng_checker.sv @@
// Port-level checks for the combined LCG shuffle generator, bound to the top level.
// Depends on crng_pkg and combined_lcg_shuffle_rng_top.
module crng_checker
  import crng_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [30:0] out_value
);

  // one item in flight: an accepted word closes the input
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while an item is in flight");

  // a new result only ends item processing
  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word appeared without an item in flight");

  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_value != 31'd0) && (out_value <= SPAN))
    else $error("result value outside 1..SPAN");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

endmodule

bind combined_lcg_shuffle_rng_top crng_checker u_crng_checker (.*);
